// File: hw/rtl/tgq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgq_pkg
// Shared widths, character codes, glyph record type and helper functions
// for the text glyph quad generator.
// ----------------------------------------------------------------------------
package tgq_pkg;

    localparam int POS_W      = 24;             // signed Q15.8 position
    localparam int CODE_W     = 8;
    localparam int SCALE_W    = 16;             // unsigned Q8.8 scale
    localparam int CELL_SHIFT = 3;              // 8x8 texel cells
    localparam int EDGE_W     = SCALE_W + CELL_SHIFT;
    localparam int TEX_W      = 8;

    localparam int ATLAS_COLUMNS = 16;
    localparam int COL_W         = $clog2(ATLAS_COLUMNS);
    localparam int ROW_W         = CODE_W - COL_W;

    localparam logic [CODE_W-1:0]  CODE_NEWLINE         = 8'd10;
    localparam logic [CODE_W-1:0]  CODE_FIRST_PRINTABLE = 8'd32;
    localparam logic [SCALE_W-1:0] SCALE_RESET          = 16'd256;

    localparam int QUEUE_DEPTH = 2;

    // vertex slot within a glyph's two triangles
    localparam int VTX_W = 3;
    localparam logic [VTX_W-1:0] VTX_0    = 3'd0;
    localparam logic [VTX_W-1:0] VTX_1    = 3'd1;
    localparam logic [VTX_W-1:0] VTX_2    = 3'd2;
    localparam logic [VTX_W-1:0] VTX_3    = 3'd3;
    localparam logic [VTX_W-1:0] VTX_4    = 3'd4;
    localparam logic [VTX_W-1:0] VTX_LAST = 3'd5;

    typedef logic signed [POS_W-1:0] pos_t;

    // one printable glyph, ready for vertex expansion
    typedef struct packed {
        pos_t              x0;
        pos_t              y0;
        pos_t              x1;
        pos_t              y1;
        logic [CODE_W-1:0] code;
    } glyph_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // position plus a non-negative edge, clamped at the positive limit
    function automatic pos_t sat_add(input pos_t a, input logic [EDGE_W-1:0] e);
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + $signed({{(POS_W+1-EDGE_W){1'b0}}, e});
        if (!s[POS_W] && s[POS_W-1])
            return {1'b0, {(POS_W-1){1'b1}}};
        return s[POS_W-1:0];
    endfunction

    // near and far texel coordinate of an atlas cell
    function automatic logic [TEX_W-1:0] cell_lo(input logic [COL_W-1:0] c);
        return {1'b0, c, {CELL_SHIFT{1'b0}}};
    endfunction

    function automatic logic [TEX_W-1:0] cell_hi(input logic [COL_W-1:0] c);
        logic [COL_W:0] n;
        n = {1'b0, c} + {{COL_W{1'b0}}, 1'b1};
        return {n, {CELL_SHIFT{1'b0}}};
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tgq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgq_if
// Valid/ready channels: character items in, vertex items out.
// ----------------------------------------------------------------------------
interface tgq_char_if;
    logic                                 valid;
    logic                                 ready;
    logic [tgq_pkg::CODE_W-1:0]           char_code;
    logic                                 string_start;
    logic signed [tgq_pkg::POS_W-1:0]     origin_x;
    logic signed [tgq_pkg::POS_W-1:0]     origin_y;

    modport source (output valid, char_code, string_start, origin_x, origin_y,
                    input ready);
    modport sink   (input valid, char_code, string_start, origin_x, origin_y,
                    output ready);
endinterface

interface tgq_vert_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tgq_pkg::POS_W-1:0]     vert_x;
    logic signed [tgq_pkg::POS_W-1:0]     vert_y;
    logic [tgq_pkg::TEX_W-1:0]            tex_u;
    logic [tgq_pkg::TEX_W-1:0]            tex_v;
    logic                                 last_vertex;

    modport source (output valid, vert_x, vert_y, tex_u, tex_v, last_vertex,
                    input ready);
    modport sink   (input valid, vert_x, vert_y, tex_u, tex_v, last_vertex,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tgq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgq_fifo
// Small register queue of glyph records between front and back.
// ----------------------------------------------------------------------------
module tgq_fifo #(
    parameter int DEPTH = tgq_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tgq_pkg::glyph_t    push_data,
    input  wire logic               pop,
    output tgq_pkg::glyph_t         head,
    output tgq_pkg::q_status_t      status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tgq_pkg::glyph_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: hw/rtl/tgq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgq_front
// Accepts character items, keeps the text cursor, queues printable glyphs.
// ----------------------------------------------------------------------------
module tgq_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tgq_char_if.sink                          in_ch,
    input  wire logic [tgq_pkg::EDGE_W-1:0]   edge_len,
    input  wire tgq_pkg::q_status_t           q_status,
    output logic                              push,
    output tgq_pkg::glyph_t                   push_data
);
    tgq_pkg::pos_t cursor_x_reg, cursor_x_next;
    tgq_pkg::pos_t cursor_y_reg, cursor_y_next;
    tgq_pkg::pos_t base_x, base_y, sum_x, sum_y;
    logic          accept, is_newline, is_control;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_newline  = (in_ch.char_code == tgq_pkg::CODE_NEWLINE);
    assign is_control  = (in_ch.char_code < tgq_pkg::CODE_FIRST_PRINTABLE);

    // string start reloads the cursor before the character is handled
    assign base_x = in_ch.string_start ? in_ch.origin_x : cursor_x_reg;
    assign base_y = in_ch.string_start ? in_ch.origin_y : cursor_y_reg;
    assign sum_x  = tgq_pkg::sat_add(base_x, edge_len);
    assign sum_y  = tgq_pkg::sat_add(base_y, edge_len);

    assign push           = accept && !is_control;
    assign push_data.x0   = base_x;
    assign push_data.y0   = base_y;
    assign push_data.x1   = sum_x;
    assign push_data.y1   = sum_y;
    assign push_data.code = in_ch.char_code;

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept)
        begin
            if (is_newline)
            begin
                cursor_x_next = '0;
                cursor_y_next = sum_y;
            end
            else
            begin
                cursor_x_next = sum_x;
                cursor_y_next = base_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tgq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgq_back
// Expands the queued glyph into six vertices, one per cycle while the output accepts them, registered out.
// ----------------------------------------------------------------------------
module tgq_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tgq_pkg::glyph_t      head,
    input  wire tgq_pkg::q_status_t   q_status,
    output logic                      pop,
    tgq_vert_if.source                out_ch
);
    logic [tgq_pkg::VTX_W-1:0] vtx_reg, vtx_next;
    logic                      out_valid_reg, out_valid_next;
    tgq_pkg::pos_t             vert_x_reg, vert_y_reg;
    logic [tgq_pkg::TEX_W-1:0] tex_u_reg, tex_v_reg;
    logic                      last_reg;
    logic                      advance, emit, use_x1, use_y1, is_last;
    logic [tgq_pkg::COL_W-1:0] col;
    logic [tgq_pkg::ROW_W-1:0] row;

    assign advance = !out_valid_reg || out_ch.ready;
    assign emit    = advance && !q_status.empty;
    assign is_last = (vtx_reg == tgq_pkg::VTX_LAST);
    assign pop     = emit && is_last;

    assign col = head.code[tgq_pkg::COL_W-1:0];
    assign row = head.code[tgq_pkg::CODE_W-1:tgq_pkg::COL_W];

    // corner order: (x0,y0) (x1,y0) (x1,y1) (x0,y0) (x1,y1) (x0,y1)
    always_comb
    begin
        case (vtx_reg)
            tgq_pkg::VTX_0:    begin use_x1 = 1'b0; use_y1 = 1'b0; end
            tgq_pkg::VTX_1:    begin use_x1 = 1'b1; use_y1 = 1'b0; end
            tgq_pkg::VTX_2:    begin use_x1 = 1'b1; use_y1 = 1'b1; end
            tgq_pkg::VTX_3:    begin use_x1 = 1'b0; use_y1 = 1'b0; end
            tgq_pkg::VTX_4:    begin use_x1 = 1'b1; use_y1 = 1'b1; end
            tgq_pkg::VTX_LAST: begin use_x1 = 1'b0; use_y1 = 1'b1; end
            default:           begin use_x1 = 1'b0; use_y1 = 1'b0; end
        endcase
    end

    always_comb
    begin
        out_valid_next = advance ? !q_status.empty : out_valid_reg;
        vtx_next       = vtx_reg;
        if (emit)
            vtx_next = is_last ? tgq_pkg::VTX_0 : vtx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            vtx_reg       <= tgq_pkg::VTX_0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            vtx_reg       <= vtx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vert_x_reg <= use_x1 ? head.x1 : head.x0;
            vert_y_reg <= use_y1 ? head.y1 : head.y0;
            tex_u_reg  <= use_x1 ? tgq_pkg::cell_hi(col) : tgq_pkg::cell_lo(col);
            tex_v_reg  <= use_y1 ? tgq_pkg::cell_hi(row) : tgq_pkg::cell_lo(row);
            last_reg   <= is_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.vert_x      = vert_x_reg;
    assign out_ch.vert_y      = vert_y_reg;
    assign out_ch.tex_u       = tex_u_reg;
    assign out_ch.tex_v       = tex_v_reg;
    assign out_ch.last_vertex = last_reg;

endmodule
`default_nettype wire

// File: hw/rtl/text_glyph_quad_generator.sv
// An item's first vertex passes the queue write and then the vertex output register before
//   it can be accepted, when the back end is idle.
// Printable characters give one vertex per cycle while the output accepts them, set by the
//   single vertex output register of the back end; control codes are not queued.
// Up to QUEUE_DEPTH glyphs wait between the cursor front end and the vertex back end.
// Reset (rst_n low, asynchronous): cursor at zero, glyph scale 256 (1.0), queue empty.
`default_nettype none
// ----------------------------------------------------------------------------
// text_glyph_quad_generator
// Lays out text as textured quads: one cursor front end feeding a vertex
// expansion back end through a short glyph queue.
// ----------------------------------------------------------------------------
module text_glyph_quad_generator #(
    parameter int QUEUE_DEPTH = tgq_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tgq_char_if.sink                           in_ch,
    tgq_vert_if.source                         out_ch,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tgq_pkg::SCALE_W-1:0]   cfg_wr_data
);
    // glyph scale register, Q8.8; to be written only while the block is idle, which the block itself does not enforce
    logic [tgq_pkg::SCALE_W-1:0] scale_reg;
    logic [tgq_pkg::EDGE_W-1:0]  edge_len;

    // glyph edge in Q15.8 units is eight times the scale
    assign edge_len = {scale_reg, {tgq_pkg::CELL_SHIFT{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= tgq_pkg::SCALE_RESET;
        else if (cfg_wr_en)
            scale_reg <= cfg_wr_data;
    end

    tgq_pkg::glyph_t    push_data;
    tgq_pkg::glyph_t    head;
    tgq_pkg::q_status_t q_status;
    logic               push;
    logic               pop;

    // front end: cursor tracking, saturating corner math, glyph enqueue
    tgq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .edge_len  (edge_len),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // glyph queue: decouples character intake from vertex output stalls
    tgq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // back end: six vertices per glyph, popped as the last one is emitted
    tgq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

`ifndef SYNTHESIS
    // a full queue must hold off character intake
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !in_ch.ready)
        else $error("character accepted while glyph queue full");

    // an accepted printable character has a vertex waiting after the queue write and the
    // vertex register stage: that register is loaded or already holds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready &&
         (in_ch.char_code >= tgq_pkg::CODE_FIRST_PRINTABLE)) |-> ##2 out_ch.valid)
        else $error("printable character produced no vertex");

    // the back end only pops a glyph the queue holds, as it emits its last vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("glyph popped from empty queue");
`endif

endmodule
`default_nettype wire

// File: bench/text_glyph_quad_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_quad_generator_tb
// Self-checking bench for the text glyph quad generator. A behavioral cursor
// and vertex predictor runs beside the block. Each sent character item adds
// its expected vertices to a queue. Every vertex item that leaves the block
// is compared with the oldest expected vertex. Directed strings, glyph scale
// extremes, output back-pressure and random text run, mostly with random idling
// on both channels.
// ----------------------------------------------------------------------------
module text_glyph_quad_generator_tb;

    localparam int CLK_PERIOD    = 20;
    localparam int DRAIN_CYCLES  = 20;      // settle time after the last vertex
    localparam int DRAIN_LIMIT   = 5000;    // bound on waiting for vertices
    localparam int SINK_HOLD_LEN = 120;     // long output stall, in cycles
    localparam int IDLE_PERCENT  = 34;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 44;
    localparam int RANDOM_PHASES = 6;
    localparam int CELL_TEXELS   = 1 << tgq_pkg::CELL_SHIFT;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    localparam tgq_pkg::pos_t POS_MAX = tgq_pkg::pos_t'(24'h7FFFFF);
    localparam tgq_pkg::pos_t POS_MIN = tgq_pkg::pos_t'(24'h800000);

    // one expected or observed vertex item
    typedef struct packed {
        tgq_pkg::pos_t             x;
        tgq_pkg::pos_t             y;
        logic [tgq_pkg::TEX_W-1:0] u;
        logic [tgq_pkg::TEX_W-1:0] v;
        logic                      last;
    } vertex_t;

    logic clk;
    logic rst_n;
    logic                         cfg_wr_en;
    logic [tgq_pkg::SCALE_W-1:0]  cfg_wr_data;

    tgq_char_if char_bus ();
    tgq_vert_if vert_bus ();

    text_glyph_quad_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (char_bus),
        .out_ch      (vert_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state: cursor and glyph scale as the block should hold them
    tgq_pkg::pos_t               cursor_x_model;
    tgq_pkg::pos_t               cursor_y_model;
    logic [tgq_pkg::SCALE_W-1:0] glyph_scale_model;

    vertex_t expected_vertices[$];

    int  fail_count;
    int  items_sent;
    bit  src_idle_en;
    bit  sink_idle_en;
    int  sink_hold_cycles;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Hard stop in case the block hangs
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout, %0d vertices still expected", expected_vertices.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // position plus glyph edge, clamped to the signed 24-bit range
    function automatic tgq_pkg::pos_t add_edge_clamped(
        input tgq_pkg::pos_t              a,
        input logic [tgq_pkg::EDGE_W-1:0] e);
        longint s;
        s = longint'(a) + longint'(e);
        if (s > longint'(POS_MAX))
            return POS_MAX;
        if (s < longint'(POS_MIN))
            return POS_MIN;
        return tgq_pkg::pos_t'(s);
    endfunction

    // Update the cursor for one character item and queue its vertices.
    task automatic predict_char(input logic [tgq_pkg::CODE_W-1:0] code, input logic start,
                                input tgq_pkg::pos_t ox, input tgq_pkg::pos_t oy);
        logic [tgq_pkg::EDGE_W-1:0] glyph_edge;
        tgq_pkg::pos_t              x0, y0, x1, y1;
        logic [tgq_pkg::TEX_W-1:0]  u0, u1, v0, v1;
        int                         col, row;
        glyph_edge = {glyph_scale_model, {tgq_pkg::CELL_SHIFT{1'b0}}};
        if (start)
        begin
            cursor_x_model = ox;
            cursor_y_model = oy;
        end
        if (code == tgq_pkg::CODE_NEWLINE)
        begin
            cursor_x_model = '0;
            cursor_y_model = add_edge_clamped(cursor_y_model, glyph_edge);
        end
        else if (code < tgq_pkg::CODE_FIRST_PRINTABLE)
        begin
            // control codes, code zero included, only advance the cursor
            cursor_x_model = add_edge_clamped(cursor_x_model, glyph_edge);
        end
        else
        begin
            col = int'(code) % tgq_pkg::ATLAS_COLUMNS;
            row = int'(code) / tgq_pkg::ATLAS_COLUMNS;
            u0  = tgq_pkg::TEX_W'(col * CELL_TEXELS);
            u1  = tgq_pkg::TEX_W'((col + 1) * CELL_TEXELS);
            v0  = tgq_pkg::TEX_W'(row * CELL_TEXELS);
            v1  = tgq_pkg::TEX_W'((row + 1) * CELL_TEXELS);   // high codes run past texel 64
            x0  = cursor_x_model;
            y0  = cursor_y_model;
            x1  = add_edge_clamped(x0, glyph_edge);
            y1  = add_edge_clamped(y0, glyph_edge);
            // two triangles: (0,0)(1,0)(1,1) and (0,0)(1,1)(0,1)
            expected_vertices.push_back('{x0, y0, u0, v0, 1'b0});
            expected_vertices.push_back('{x1, y0, u1, v0, 1'b0});
            expected_vertices.push_back('{x1, y1, u1, v1, 1'b0});
            expected_vertices.push_back('{x0, y0, u0, v0, 1'b0});
            expected_vertices.push_back('{x1, y1, u1, v1, 1'b0});
            expected_vertices.push_back('{x0, y1, u0, v1, 1'b1});
            cursor_x_model = x1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Vertex sink: samples at the falling edge so the value seen is the one
    // the block presents at the next rising edge, then checks and drives
    // ready at that rising edge.
    // ------------------------------------------------------------------------
    initial
    begin : vertex_sink
        vertex_t seen;
        vertex_t want;
        logic    fire;
        vert_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            fire = (vert_bus.valid === 1'b1) && (vert_bus.ready === 1'b1);
            seen = '{vert_bus.vert_x, vert_bus.vert_y, vert_bus.tex_u, vert_bus.tex_v,
                     vert_bus.last_vertex};
            @(posedge clk);
            if (fire)
            begin
                if (expected_vertices.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: unexpected vertex x=%0d y=%0d u=%0d v=%0d last=%0b",
                                 seen.x, seen.y, seen.u, seen.v, seen.last);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"ERROR: vertex mismatch exp x=%0d y=%0d u=%0d v=%0d ",
                                      "last=%0b got x=%0d y=%0d u=%0d v=%0d last=%0b"},
                                     want.x, want.y, want.u, want.v, want.last,
                                     seen.x, seen.y, seen.u, seen.v, seen.last);
                    end
                end
            end
            // a requested hold-off is counted down here, once per rising edge
            if (sink_hold_cycles > 0)
            begin
                vert_bus.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else
                vert_bus.ready <= !(sink_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT));
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks; all start and end right after a rising edge
    // ------------------------------------------------------------------------

    // Offer one character item and wait until the block takes it. Valid stays
    // high on return so a back-to-back item needs no extra assignment.
    task automatic send_char(input logic [tgq_pkg::CODE_W-1:0] code, input logic start,
                             input tgq_pkg::pos_t ox, input tgq_pkg::pos_t oy);
        logic taken;
        while (src_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.char_code    <= code;
        char_bus.string_start <= start;
        char_bus.origin_x     <= ox;
        char_bus.origin_y     <= oy;
        predict_char(code, start, ox, oy);
        items_sent++;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (char_bus.ready === 1'b1);
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every expected vertex, then let the block
    // settle; control items leave nothing to wait for, hence the extra cycles.
    task automatic wait_drained();
        int waited;
        char_bus.valid <= 1'b0;
        waited = 0;
        while (expected_vertices.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_vertices.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d expected vertices never arrived", expected_vertices.size());
            expected_vertices.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Scale writes happen only with the block idle.
    task automatic set_glyph_scale(input logic [tgq_pkg::SCALE_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        glyph_scale_model = value;
    endtask

    // small origins most of the time, anywhere in range otherwise
    function automatic tgq_pkg::pos_t random_origin();
        if ($urandom_range(0, 3) == 0)
            return tgq_pkg::pos_t'($urandom);
        return tgq_pkg::pos_t'(int'($urandom_range(0, 65535)) - 32768);
    endfunction

    // mostly printable text, some newlines and other control codes
    function automatic logic [tgq_pkg::CODE_W-1:0] random_text_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return tgq_pkg::CODE_W'($urandom_range(32, 255));
        if (pick < 88)
            return tgq_pkg::CODE_NEWLINE;
        return tgq_pkg::CODE_W'($urandom_range(0, 31));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset scale, every code class, ignored origins and cursor saturation.
    task automatic test_directed_codes();
        send_char("A", 1'b1, '0, '0);
        send_char(" ", 1'b0, POS_MAX, POS_MIN);            // origin ignored
        send_char(8'd126, 1'b0, '0, '0);
        send_char(8'd127, 1'b0, '0, '0);
        send_char(8'd128, 1'b0, '0, '0);                   // row past the atlas
        send_char(8'd255, 1'b0, '1, '1);                   // last cell, v up to 128
        send_char(8'd0, 1'b0, '0, '0);                     // zero is just a control code
        send_char(8'd1, 1'b0, '0, '0);
        send_char(8'd31, 1'b0, '0, '0);
        send_char(tgq_pkg::CODE_NEWLINE, 1'b0, '0, '0);
        send_char("H", 1'b0, '0, '0);
        // both corners clamp at the positive limit
        send_char("Z", 1'b1, POS_MAX, POS_MAX);
        send_char(8'd9, 1'b0, '0, '0);
        send_char(tgq_pkg::CODE_NEWLINE, 1'b0, '0, '0);
        send_char("z", 1'b0, '0, '0);
        send_char("m", 1'b1, POS_MIN, POS_MIN);
        send_char("q", 1'b1, tgq_pkg::pos_t'(24'h7FF800), tgq_pkg::pos_t'(24'h7FFC00));
        send_char(tgq_pkg::CODE_NEWLINE, 1'b1, tgq_pkg::pos_t'(24'h123456),
                  tgq_pkg::pos_t'(24'hABCDEF));
        send_char("@", 1'b0, '0, '0);
        wait_drained();
    endtask

    // Smallest, largest and zero scale, then back to unity.
    task automatic test_scale_extremes();
        logic [tgq_pkg::SCALE_W-1:0] scales[4];
        scales = '{16'd1, 16'hFFFF, 16'd0, tgq_pkg::SCALE_RESET};
        foreach (scales[i])
        begin
            set_glyph_scale(scales[i]);
            send_char("W", 1'b1, random_origin(), random_origin());
            send_char("x", 1'b0, '0, '0);
            send_char(8'd5, 1'b0, '0, '0);
            send_char(tgq_pkg::CODE_NEWLINE, 1'b0, '0, '0);
            send_char("y", 1'b0, '0, '0);
        end
        wait_drained();
    endtask

    // Output held off while the sender keeps offering glyphs, so the glyph
    // queue fills and input ready drops; then the sender waits for all.
    task automatic test_output_backpressure();
        set_glyph_scale(16'd384);
        src_idle_en      = 1'b0;
        sink_hold_cycles = SINK_HOLD_LEN;
        send_char("B", 1'b1, random_origin(), random_origin());
        repeat (11)
            send_char(tgq_pkg::CODE_W'($urandom_range(32, 255)), 1'b0, '0, '0);
        wait_drained();
        src_idle_en = 1'b1;
    endtask

    // Random strings with random content, some noise items, several scales.
    task automatic test_random_text();
        int                         phase_start;
        int                         len;
        logic [tgq_pkg::CODE_W-1:0] code;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                set_glyph_scale(tgq_pkg::SCALE_W'($urandom_range(1, 65535)));
            else
                set_glyph_scale(tgq_pkg::SCALE_W'($urandom_range(1, 1024)));
            // one phase runs with no idling on either side
            src_idle_en  = (phase != 3);
            sink_idle_en = (phase != 3);
            phase_start  = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // noise: anything goes, start bit included
                    code = tgq_pkg::CODE_W'($urandom_range(0, 255));
                    send_char(code, 1'($urandom), tgq_pkg::pos_t'($urandom),
                              tgq_pkg::pos_t'($urandom));
                end
                else
                begin
                    len = $urandom_range(1, 12);
                    send_char(random_text_code(), 1'b1, random_origin(), random_origin());
                    for (int i = 1; i < len; i++)
                        send_char(random_text_code(), 1'b0, tgq_pkg::pos_t'($urandom),
                                  tgq_pkg::pos_t'($urandom));
                end
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        rst_n                 = 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        char_bus.valid        <= 1'b0;
        char_bus.char_code    <= '0;
        char_bus.string_start <= 1'b0;
        char_bus.origin_x     <= '0;
        char_bus.origin_y     <= '0;
        fail_count        = 0;
        items_sent        = 0;
        src_idle_en       = 1'b1;
        sink_idle_en      = 1'b1;
        sink_hold_cycles  = 0;
        cursor_x_model    = '0;
        cursor_y_model    = '0;
        glyph_scale_model = tgq_pkg::SCALE_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_codes();
        test_scale_extremes();
        test_output_backpressure();
        test_random_text();

        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tgq_pkg.sv
hw/rtl/tgq_if.sv
hw/rtl/tgq_fifo.sv
hw/rtl/tgq_front.sv
hw/rtl/tgq_back.sv
hw/rtl/text_glyph_quad_generator.sv
bench/text_glyph_quad_generator_tb.sv
